/* hw/rtl/dpq_pkg.sv */
// Package with the types, codes and helper function of the deadline priority queue.
`default_nettype none
package dpq_pkg;

   localparam logic [15:0] YEAR_DAYS  = 16'd365;
   localparam logic [15:0] MONTH_DAYS = 16'd30;
   localparam int          ENTRY_BITS = 32;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_DELETE = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_PLACE,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic [7:0]  tag;
      logic [7:0]  prio;
      logic [15:0] key;
   } entry_type;

   // An entry stays ahead of a new task if it is due earlier, or due at the
   // same time with at least the same priority.
   function automatic logic stays_ahead(input entry_type e, input logic [15:0] key,
                                        input logic [7:0] prio);
      stays_ahead = (e.key < key) || ((e.key == key) && (e.prio >= prio));
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/dpq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module dpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

/* hw/rtl/deadline_priority_queue.sv */
// Top level of the deadline priority queue: sequencer, entry memory and result port.
// The result strobe comes in the cycle after acceptance for a no-op, a dropped push and a pop
// or delete on an empty queue; a push into an empty queue passes ST_PLACE, then ST_RESPOND.
// Otherwise each entry visited takes a memory read (ST_READ) and a compare (ST_CHECK): a pop
// visits all but the head, a delete every entry, a push the entries from the tail to its slot.
// Busy falls after the strobe; the next item is accepted in the cycle after it at the soonest.
// Synchronous reset empties the queue; the results cannot be stalled.
`default_nettype none
module deadline_priority_queue
   import dpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [7:0]  req_task_id,
   input  wire logic [7:0]  req_task_priority,
   input  wire logic [4:0]  req_due_day,
   input  wire logic [3:0]  req_due_month,
   input  wire logic [6:0]  req_due_year,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic             rsp_head_valid,
   output logic [7:0]       rsp_head_tag,
   output logic [7:0]       rsp_head_prio,
   output logic [15:0]      rsp_head_key,
   output logic [4:0]       rsp_entry_count
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   state_type        state_ff, state_in;
   opcode_type       op_ff, op_in;
   status_type       status_ff, status_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic             found_ff, found_in;
   entry_type        new_ff, new_in;
   entry_type        head_ff, head_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   entry_type        wr_data;
   entry_type        rd_data;
   logic [CW-1:0]    next_pos;
   logic [15:0]      req_key;

   dpq_ram #(
      .WIDTH(ENTRY_BITS),
      .DEPTH(QUEUE_DEPTH)
   ) u_entries (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(idx_ff),
      .rd_data(rd_data)
   );

   assign req_key  = 16'(req_due_year) * YEAR_DAYS + 16'(req_due_month) * MONTH_DAYS
                   + 16'(req_due_day);
   assign next_pos = CW'(idx_ff) + CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      op_ff     <= op_in;
      status_ff <= status_in;
      idx_ff    <= idx_in;
      found_ff  <= found_in;
      new_ff    <= new_in;
      head_ff   <= head_in;
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      status_in = status_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      found_in  = found_ff;
      new_in    = new_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = new_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in      = opcode_type'(req_opcode);
               new_in.tag  = req_task_id;
               new_in.prio = req_task_priority;
               new_in.key  = req_key;
               status_in  = STATUS_OK;
               found_in   = 1'b0;
               idx_in     = '0;
               state_in   = ST_RESPOND;
               case (opcode_type'(req_opcode))
                  OP_PUSH: begin
                     if (count_ff >= CW'(QUEUE_DEPTH)) begin
                        status_in = STATUS_FULL;
                     end else if (count_ff == '0) begin
                        state_in = ST_PLACE;
                     end else begin
                        idx_in   = AW'(count_ff - CW'(1));
                        state_in = ST_READ;
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else if (count_ff == CW'(1)) begin
                        count_in = '0;
                     end else begin
                        found_in = 1'b1;
                        idx_in   = AW'(1);
                        state_in = ST_READ;
                     end
                  end
                  OP_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_NOT_FOUND;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (op_ff == OP_PUSH) begin
               wr_en   = 1'b1;
               wr_addr = AW'(next_pos);
               if (stays_ahead(rd_data, new_ff.key, new_ff.prio)) begin
                  wr_data  = new_ff;
                  count_in = count_ff + CW'(1);
                  state_in = ST_RESPOND;
               end else begin
                  wr_data = rd_data;
                  if (idx_ff == '0) begin
                     state_in = ST_PLACE;
                  end else begin
                     idx_in   = idx_ff - AW'(1);
                     state_in = ST_READ;
                  end
               end
            end else begin
               if (found_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = idx_ff - AW'(1);
                  wr_data = rd_data;
               end
               if (found_ff || (rd_data.tag == new_ff.tag)) begin
                  found_in = 1'b1;
                  if (next_pos < count_ff) begin
                     idx_in   = AW'(next_pos);
                     state_in = ST_READ;
                  end else begin
                     count_in = count_ff - CW'(1);
                     state_in = ST_RESPOND;
                  end
               end else if (next_pos < count_ff) begin
                  idx_in   = AW'(next_pos);
                  state_in = ST_READ;
               end else begin
                  status_in = STATUS_NOT_FOUND;
                  state_in  = ST_RESPOND;
               end
            end
         end
         ST_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = new_ff;
            count_in = count_ff + CW'(1);
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The head register mirrors entry zero of the memory.
   assign head_in = (wr_en && (wr_addr == '0)) ? wr_data : head_ff;

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_RESPOND);
   assign rsp_status      = status_ff;
   assign rsp_head_valid  = (count_ff != '0);
   assign rsp_head_tag    = rsp_head_valid ? head_ff.tag : 8'd0;
   assign rsp_head_prio   = rsp_head_valid ? head_ff.prio : 8'd0;
   assign rsp_head_key    = rsp_head_valid ? head_ff.key : 16'd0;
   assign rsp_entry_count = 5'(count_ff);

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("entry count exceeds the queue depth");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe held longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL) |-> count_ff == CW'(QUEUE_DEPTH))
      else $error("push dropped while the queue was not full");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) && (state_in == ST_IDLE) |=> $stable(count_ff))
      else $error("entry count changed outside an item");
`endif

endmodule
`default_nettype wire

/* tb/tb_deadline_priority_queue.sv */
// Self-checking testbench of the deadline priority queue: directed and random items.
`timescale 1ns / 100ps

module tb_deadline_priority_queue;
   import dpq_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_LIMIT = 4000;

   typedef struct {
      status_type  status;
      logic        head_valid;
      logic [7:0]  head_tag;
      logic [7:0]  head_prio;
      logic [15:0] head_key;
      logic [4:0]  entry_count;
   } queue_outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode = 2'd0;
   logic [7:0]  req_task_id = 8'd0;
   logic [7:0]  req_task_priority = 8'd0;
   logic [4:0]  req_due_day = 5'd0;
   logic [3:0]  req_due_month = 4'd0;
   logic [6:0]  req_due_year = 7'd0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic        rsp_head_valid;
   logic [7:0]  rsp_head_tag;
   logic [7:0]  rsp_head_prio;
   logic [15:0] rsp_head_key;
   logic [4:0]  rsp_entry_count;

   entry_type         shadow_entries[QUEUE_DEPTH];
   int                shadow_count = 0;
   queue_outcome_type pending_outcomes[$];
   int                items_sent = 0;
   int                results_seen = 0;
   int                mismatch_count = 0;

   deadline_priority_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_task_id(req_task_id),
      .req_task_priority(req_task_priority),
      .req_due_day(req_due_day),
      .req_due_month(req_due_month),
      .req_due_year(req_due_year),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_head_valid(rsp_head_valid),
      .rsp_head_tag(rsp_head_tag),
      .rsp_head_prio(rsp_head_prio),
      .rsp_head_key(rsp_head_key),
      .rsp_entry_count(rsp_entry_count)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 100) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
   endtask

   function automatic queue_outcome_type apply_to_shadow(input opcode_type op,
         input logic [7:0] id, input logic [7:0] prio, input logic [4:0] day,
         input logic [3:0] month, input logic [6:0] year);
      queue_outcome_type outcome;
      logic [15:0]       key;
      int                pos;
      key = 16'(year) * YEAR_DAYS + 16'(month) * MONTH_DAYS + 16'(day);
      outcome.status = STATUS_OK;
      case (op)
         OP_PUSH: begin
            if (shadow_count >= QUEUE_DEPTH) begin
               outcome.status = STATUS_FULL;
            end else begin
               pos = 0;
               while (pos < shadow_count && (shadow_entries[pos].key < key ||
                      (shadow_entries[pos].key == key && shadow_entries[pos].prio >= prio))) begin
                  pos++;
               end
               for (int i = shadow_count; i > pos; i--) begin
                  shadow_entries[i] = shadow_entries[i - 1];
               end
               shadow_entries[pos] = '{tag: id, prio: prio, key: key};
               shadow_count++;
            end
         end
         OP_POP: begin
            if (shadow_count == 0) begin
               outcome.status = STATUS_EMPTY;
            end else begin
               for (int i = 0; i + 1 < shadow_count; i++) begin
                  shadow_entries[i] = shadow_entries[i + 1];
               end
               shadow_count--;
            end
         end
         OP_DELETE: begin
            pos = -1;
            for (int i = 0; i < shadow_count; i++) begin
               if (pos < 0 && shadow_entries[i].tag == id) begin
                  pos = i;
               end
            end
            if (pos < 0) begin
               outcome.status = STATUS_NOT_FOUND;
            end else begin
               for (int i = pos; i + 1 < shadow_count; i++) begin
                  shadow_entries[i] = shadow_entries[i + 1];
               end
               shadow_count--;
            end
         end
         default: begin
         end
      endcase
      outcome.head_valid = (shadow_count > 0);
      outcome.head_tag = (shadow_count > 0) ? shadow_entries[0].tag : 8'd0;
      outcome.head_prio = (shadow_count > 0) ? shadow_entries[0].prio : 8'd0;
      outcome.head_key = (shadow_count > 0) ? shadow_entries[0].key : 16'd0;
      outcome.entry_count = 5'(shadow_count);
      return outcome;
   endfunction

   always @(posedge clock) begin
      queue_outcome_type want;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            results_seen++;
            if (pending_outcomes.size() == 0) begin
               report_mismatch("result strobe with no item outstanding");
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_status !== want.status || rsp_head_valid !== want.head_valid ||
                   rsp_head_tag !== want.head_tag || rsp_head_prio !== want.head_prio ||
                   rsp_head_key !== want.head_key || rsp_entry_count !== want.entry_count) begin
                  report_mismatch($sformatf(
                     "status %0d/%0d valid %b/%b tag %h/%h prio %h/%h key %0d/%0d count %0d/%0d",
                     rsp_status, want.status, rsp_head_valid, want.head_valid,
                     rsp_head_tag, want.head_tag, rsp_head_prio, want.head_prio,
                     rsp_head_key, want.head_key, rsp_entry_count, want.entry_count));
               end
            end
         end
         if (start && busy === 1'b0) begin
            pending_outcomes.push_back(apply_to_shadow(opcode_type'(req_opcode), req_task_id,
               req_task_priority, req_due_day, req_due_month, req_due_year));
         end
      end
   end

   task automatic send_item(input opcode_type op, input logic [7:0] id, input logic [7:0] prio,
         input logic [4:0] day, input logic [3:0] month, input logic [6:0] year,
         input int idle_pct);
      req_opcode <= op;
      req_task_id <= id;
      req_task_priority <= prio;
      req_due_day <= day;
      req_due_month <= month;
      req_due_year <= year;
      start <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) begin
         @(posedge clock);
      end
      items_sent++;
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      int guard;
      guard = 0;
      start <= 1'b0;
      while (results_seen != items_sent && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
   endtask

   task automatic test_empty_queue();
      send_item(OP_POP, 8'h00, 8'h00, 5'd0, 4'd0, 7'd0, 0);
      send_item(OP_DELETE, 8'h00, 8'h00, 5'd0, 4'd0, 7'd0, 0);
      send_item(OP_NOP, 8'hFF, 8'hFF, 5'd31, 4'd15, 7'd127, 0);
      send_item(OP_DELETE, 8'hFF, 8'h00, 5'd0, 4'd0, 7'd0, 0);
   endtask

   task automatic test_fill_and_full();
      send_item(OP_PUSH, 8'hFF, 8'h00, 5'd31, 4'd15, 7'd127, 0);
      send_item(OP_PUSH, 8'h00, 8'hFF, 5'd0, 4'd0, 7'd0, 0);
      send_item(OP_PUSH, 8'h01, 8'h10, 5'd1, 4'd1, 7'd0, 0);
      send_item(OP_PUSH, 8'h02, 8'h20, 5'd1, 4'd1, 7'd0, 0);
      send_item(OP_PUSH, 8'h03, 8'h20, 5'd1, 4'd1, 7'd0, 0);
      send_item(OP_PUSH, 8'h04, 8'h10, 5'd1, 4'd1, 7'd0, 0);
      for (int i = 0; i < QUEUE_DEPTH - 6; i++) begin
         send_item(OP_PUSH, 8'(8'h10 + i), 8'(i * 25), 5'(1 + i * 3), 4'(1 + i),
            7'(99 - i * 10), 0);
      end
      send_item(OP_PUSH, 8'hAA, 8'h55, 5'd0, 4'd0, 7'd0, 0);
      send_item(OP_DELETE, 8'h03, 8'h00, 5'd0, 4'd0, 7'd0, 0);
      send_item(OP_DELETE, 8'h77, 8'h00, 5'd0, 4'd0, 7'd0, 0);
      send_item(OP_DELETE, 8'h00, 8'h00, 5'd0, 4'd0, 7'd0, 0);
      send_item(OP_NOP, 8'h00, 8'h00, 5'd0, 4'd0, 7'd0, 0);
      send_item(OP_POP, 8'h00, 8'h00, 5'd0, 4'd0, 7'd0, 0);
   endtask

   task automatic test_random_traffic(input int n_items, input int idle_pct);
      int          push_pct;
      int          pick;
      opcode_type  op;
      logic [7:0]  id;
      logic [7:0]  prio;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [6:0]  year;
      push_pct = 50;
      for (int i = 0; i < n_items; i++) begin
         if (i % 32 == 0) begin
            case ($urandom_range(0, 2))
               0: push_pct = 25;
               1: push_pct = 50;
               default: push_pct = 85;
            endcase
         end
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            op = OP_NOP;
         end else if (pick < push_pct) begin
            op = OP_PUSH;
         end else if (pick < push_pct + (100 - push_pct) / 2) begin
            op = OP_POP;
         end else begin
            op = OP_DELETE;
         end
         id = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
         prio = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
         if ($urandom_range(0, 1) == 1) begin
            day = 5'($urandom_range(0, 3));
            month = 4'($urandom_range(0, 1));
            year = 7'($urandom_range(0, 1));
         end else begin
            day = 5'($urandom_range(0, 31));
            month = 4'($urandom_range(0, 15));
            year = 7'($urandom_range(0, 127));
         end
         send_item(op, id, prio, day, month, year, idle_pct);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_queue();
      test_fill_and_full();
      wait_for_results();
      test_random_traffic(600, 0);
      test_random_traffic(500, 56);
      wait_for_results();
      test_random_traffic(500, 14);
      test_random_traffic(150, 0);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_outcomes.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", pending_outcomes.size()));
      end
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
